@@ rtl/core/pfr_pkg.sv @@
package pfr_pkg;

  // shared divider geometry
  localparam int DIV_W      = 16;
  localparam int DIVISOR_W  = 8;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_CYCLES = DIV_W / DIV_STEPS;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

  // register indexes
  localparam logic [1:0] REG_MODE    = 2'd0;
  localparam logic [1:0] REG_FAN     = 2'd1;
  localparam logic [1:0] REG_TARGET  = 2'd2;
  localparam logic [1:0] REG_TIMEOUT = 2'd3;

  // register reset values
  localparam logic        MODE_RST    = 1'b0;
  localparam logic [6:0]  FAN_RST     = 7'd50;
  localparam logic [6:0]  TARGET_RST  = 7'd25;
  localparam logic [15:0] TIMEOUT_RST = 16'd5000;

  // arithmetic constants
  localparam logic [DIVISOR_W-1:0] RAW_DIV  = 8'd240;
  localparam logic [DIVISOR_W-1:0] PRES_DEN = 8'd100;
  localparam logic [6:0]           PRES_NUM = 7'd95;
  localparam logic [7:0]           FAN_SCALE  = 8'd200;
  localparam logic [3:0]           STEP_SCALE = 4'd10;
  localparam logic [14:0]          FREQ_MAX   = 15'd20000;
  localparam logic [15:0]          TIMER_MAX  = 16'hffff;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RAW,
    ST_SCALE,
    ST_DECIDE,
    ST_RATIO,
    ST_FINISH
  } pfr_state_e;

  typedef enum logic [2:0] {
    ACT_FAN,
    ACT_HOLD,
    ACT_RAISE,
    ACT_LOWER,
    ACT_ZERO
  } pfr_act_e;

  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     dividend;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ rtl/core/pfr_div.sv @@
module pfr_div
  import pfr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0]     work_q, work_d;
  logic [DIVISOR_W-1:0] rem_q, rem_d;
  logic [DIVISOR_W-1:0] divisor_q;
  logic [DIVISOR_W:0]   cand;

  // restoring division, two quotient bits per cycle
  always_comb begin
    rem_d  = rem_q;
    work_d = work_q;
    cand   = '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      cand   = {rem_d, work_d[DIV_W-1]};
      work_d = {work_d[DIV_W-2:0], 1'b0};
      if (cand >= {1'b0, divisor_q}) begin
        cand      = cand - {1'b0, divisor_q};
        work_d[0] = 1'b1;
      end
      rem_d = cand[DIVISOR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      work_q    <= req_i.dividend;
      rem_q     <= '0;
      divisor_q <= req_i.divisor;
    end else if (busy_q) begin
      work_q <= work_d;
      rem_q  <= rem_d;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = work_q;

endmodule

@@ rtl/core/pressure_ratio_fan_regulator_top.sv @@
// channel | direction | handshake                   | payload
// in      | input     | in_valid_i / in_stall_o     | raw_pressure_i, elapsed_ticks_i
// out     | output    | out_valid_o / out_stall_i   | drive_frequency_o, pressure_value_o,
//         |           |                             | not_reached_o
// cfg     | input     | cfg_we_i                    | cfg_idx_i, cfg_wdata_i
//
// an item passes the raw and scale divisions, a decide step, a ratio division when a
// ratio step is needed, and a finish step: every division goes through one shared
// divider that retires two bits a cycle, with up to three passes per item
// in_stall_o is high from accept until the result is loaded into the output register
// a stalled result holds the block in its last state; a new word is still taken
// once the result sits in the output register
// reset clears control state and loads register defaults; no clearing pass
module pressure_ratio_fan_regulator_top
  import pfr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] raw_pressure_i,
  input  logic        [15:0] elapsed_ticks_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic        [14:0] drive_frequency_o,
  output logic signed [8:0]  pressure_value_o,
  output logic               not_reached_o,
  input  logic               cfg_we_i,
  input  logic        [1:0]  cfg_idx_i,
  input  logic        [15:0] cfg_wdata_i
);

  pfr_state_e state_q, state_d;
  pfr_act_e   act_q, act_d;

  logic        mode_q;
  logic [6:0]  fan_q;
  logic [6:0]  target_q;
  logic [15:0] timeout_q;

  logic [14:0] freq_q;
  logic [15:0] timer_q, timer_d;
  logic        out_valid_q;
  logic signed [8:0] pres_out_q;
  logic        alarm_q, alarm_d;

  logic        raw_neg_q;
  logic [15:0] ticks_q;
  logic signed [8:0] q_q;
  logic        step_neg_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic        accept;
  logic        out_free;
  logic        fin_go;
  logic [15:0] raw_mag;
  logic [15:0] scale_num;
  logic signed [8:0] q_new;
  logic signed [8:0] tgt_s;
  logic        q_eq;
  logic        q_above;
  logic [7:0]  q_mag;
  logic [15:0] ratio_num;
  logic [7:0]  ratio_den;
  logic        need_div;
  logic [14:0] step_mag;
  logic signed [16:0] f_cur;
  logic signed [16:0] f_new;
  logic [14:0] freq_d;
  logic [16:0] timer_sum;
  logic [15:0] timer_sat;

  pfr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign accept   = (state_q == ST_IDLE) && in_valid_i;
  assign out_free = !out_valid_q || !out_stall_i;
  assign fin_go   = (state_q == ST_FINISH) && out_free;

  assign raw_mag   = raw_pressure_i[15] ? (~raw_pressure_i + 16'd1) : raw_pressure_i;
  assign scale_num = 16'(div_rsp.quotient[7:0] * PRES_NUM);
  assign q_new     = raw_neg_q ? -$signed({1'b0, div_rsp.quotient[7:0]})
                               : $signed({1'b0, div_rsp.quotient[7:0]});

  // pressure against target
  assign tgt_s   = $signed({2'b00, target_q});
  assign q_eq    = (q_q == tgt_s);
  assign q_above = (tgt_s > q_q);
  assign q_mag   = q_q[8] ? 8'(-q_q) : q_q[7:0];

  always_comb begin
    act_d     = ACT_HOLD;
    need_div  = 1'b0;
    ratio_num = 16'(target_q * STEP_SCALE);
    ratio_den = (q_q == '0) ? 8'd1 : q_mag;
    if (!mode_q) begin
      act_d = ACT_FAN;
    end else if (q_eq) begin
      act_d = ACT_HOLD;
    end else if (q_above) begin
      act_d    = ACT_RAISE;
      need_div = 1'b1;
    end else if (target_q == '0) begin
      act_d = ACT_ZERO;
    end else begin
      act_d     = ACT_LOWER;
      need_div  = 1'b1;
      ratio_num = 16'(q_mag * STEP_SCALE);
      ratio_den = {1'b0, target_q};
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_RAW;
      ST_RAW:    if (div_rsp.done) state_d = ST_SCALE;
      ST_SCALE:  if (div_rsp.done) state_d = ST_DECIDE;
      ST_DECIDE: state_d = need_div ? ST_RATIO : ST_FINISH;
      ST_RATIO:  if (div_rsp.done) state_d = ST_FINISH;
      ST_FINISH: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // divider requests
  always_comb begin
    div_req = '0;
    case (state_q)
      ST_IDLE: begin
        div_req.start    = in_valid_i;
        div_req.dividend = raw_mag;
        div_req.divisor  = RAW_DIV;
      end
      ST_RAW: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = scale_num;
        div_req.divisor  = PRES_DEN;
      end
      ST_DECIDE: begin
        div_req.start    = need_div;
        div_req.dividend = ratio_num;
        div_req.divisor  = ratio_den;
      end
      default: div_req = '0;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  // frequency update
  assign step_mag = 15'(div_rsp.quotient[10:0] * STEP_SCALE);
  assign f_cur    = $signed({2'b00, freq_q});

  always_comb begin
    f_new = f_cur;
    case (act_q)
      ACT_FAN:   f_new = $signed({2'b00, 15'(fan_q * FAN_SCALE)});
      ACT_HOLD:  f_new = f_cur;
      ACT_RAISE: f_new = step_neg_q ? f_cur - $signed({2'b00, step_mag})
                                    : f_cur + $signed({2'b00, step_mag});
      ACT_LOWER: f_new = f_cur - $signed({2'b00, step_mag});
      ACT_ZERO:  f_new = '0;
      default:   f_new = f_cur;
    endcase
    if (f_new < 0) begin
      freq_d = '0;
    end else if (f_new > $signed({2'b00, FREQ_MAX})) begin
      freq_d = FREQ_MAX;
    end else begin
      freq_d = f_new[14:0];
    end
  end

  // wait timer
  assign timer_sum = {1'b0, timer_q} + {1'b0, ticks_q};
  assign timer_sat = timer_sum[16] ? TIMER_MAX : timer_sum[15:0];

  always_comb begin
    timer_d = timer_sat;
    alarm_d = 1'b0;
    if (mode_q) begin
      if (!q_eq && (timer_sat >= timeout_q)) begin
        alarm_d = 1'b1;
        timer_d = '0;
      end else if (q_eq) begin
        timer_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_RST;
      fan_q       <= FAN_RST;
      target_q    <= TARGET_RST;
      timeout_q   <= TIMEOUT_RST;
      freq_q      <= '0;
      timer_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MODE:    mode_q    <= cfg_wdata_i[0];
          REG_FAN:     fan_q     <= cfg_wdata_i[6:0];
          REG_TARGET:  target_q  <= cfg_wdata_i[6:0];
          REG_TIMEOUT: timeout_q <= cfg_wdata_i;
          default:     mode_q    <= mode_q;
        endcase
        timer_q <= '0;
      end else if (fin_go) begin
        timer_q <= timer_d;
      end
      if (fin_go) begin
        freq_q      <= freq_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      raw_neg_q <= raw_pressure_i[15];
      ticks_q   <= elapsed_ticks_i;
    end
    if ((state_q == ST_SCALE) && div_rsp.done) begin
      q_q <= q_new;
    end
    if (state_q == ST_DECIDE) begin
      act_q      <= act_d;
      step_neg_q <= q_q[8];
    end
    if (fin_go) begin
      pres_out_q <= q_q;
      alarm_q    <= alarm_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign drive_frequency_o = freq_q;
  assign pressure_value_o  = pres_out_q;
  assign not_reached_o     = alarm_q;

endmodule

@@ rtl/core/pfr_checker.sv @@
module pfr_checker
  import pfr_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic        [14:0] drive_frequency_o,
  input logic signed [8:0]  pressure_value_o,
  input logic               not_reached_o
);

  // a stalled word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(drive_frequency_o)
      && $stable(pressure_value_o) && $stable(not_reached_o))
    else $error("stalled output word changed");

  // frequency never exceeds the saturation limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> drive_frequency_o <= FREQ_MAX)
    else $error("drive frequency above limit");

  // scaled pressure fits the sensor range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pressure_value_o <= 9'sd129) && (pressure_value_o >= -9'sd129))
    else $error("pressure value out of range");

  // accepting a word makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  // a new result only appears as the block goes idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("result appeared while busy");

endmodule

bind pressure_ratio_fan_regulator_top pfr_checker u_pfr_checker (.*);
